// ----- design/svd_pkg.sv -----
// Shared types and fixed constants of the sine voice with release decay.
package svd_pkg;

    // Field widths of the item ports.
    localparam int REQ_W    = 2;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 16;
    localparam int SAMPLE_W = 16;

    // Internal fixed-point widths.
    localparam int AMP_W      = 16;
    localparam int TAIL_W     = 17;
    localparam int SINE_MAG_W = 15;
    localparam int MUL_A_W    = 31;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int NOTE_COUNT = 128;

    // Q16 coefficients: level scale 0.15, decay 0.99, tail 1.0 and end level 0.005.
    localparam logic [MUL_B_W-1:0] AMP_COEF   = 17'd9830;
    localparam logic [MUL_B_W-1:0] DECAY_COEF = 17'd64881;
    localparam logic [TAIL_W-1:0]  TAIL_ONE   = 17'h10000;
    localparam logic [TAIL_W-1:0]  TAIL_END   = 17'd327;

    // Top-octave note frequencies (notes 120 to 131) in Q16.16.
    localparam logic [31:0] TOP_OCTAVE_Q16 [0:11] = '{
        32'd548668578, 32'd581294109, 32'd615859655, 32'd652480571,
        32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
        32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
    };

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_MUL,
        ST_START_LOAD,
        ST_MUL_LVL,
        ST_MUL_TAIL,
        ST_ROUND,
        ST_EMIT
    } t_state;

endpackage

// ----- design/svd_tables.sv -----
// Build-time phase step and quarter-wave sine tables with registered reads.
module svd_tables #(
    parameter int SAMPLE_RATE     = 48000,
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                i_clk,
    input  logic [svd_pkg::NOTE_W-1:0]          i_note,
    input  logic [SINE_TABLE_BITS-1:0]          i_phase_idx,
    output logic [PHASE_BITS-1:0]               o_step,
    output logic [svd_pkg::SINE_MAG_W-1:0]      o_sine_mag,
    output logic                                o_sine_neg
);
    import svd_pkg::*;

    localparam int QBITS = SINE_TABLE_BITS - 2;
    localparam int QSIZE = 1 << QBITS;
    localparam logic [63:0] PHASE_MASK = (64'd1 << PHASE_BITS) - 64'd1;

    logic [PHASE_BITS-1:0] step_rom [NOTE_COUNT];
    logic [SINE_MAG_W-1:0] sine_rom [QSIZE+1];

    logic [1:0]            quad;
    logic [QBITS:0]        rom_idx;
    logic [SINE_MAG_W-1:0] rom_mag;

    // Step for each note: the top-octave frequency shifted down by the octave,
    // scaled to a phase increment with one rounded division.
    for (genvar g = 0; g < NOTE_COUNT; g++) begin : g_step
        localparam int OCT = g / 12;
        localparam logic [63:0] NUM = {32'd0, TOP_OCTAVE_Q16[g % 12]} << PHASE_BITS;
        localparam logic [63:0] DEN = (64'(SAMPLE_RATE) << 16) << (10 - OCT);
        localparam logic [63:0] RAW = ((NUM + DEN / 2) / DEN) & PHASE_MASK;
        localparam logic [63:0] STEP = (RAW == 64'd0) ? 64'd1 : RAW;
        assign step_rom[g] = STEP[PHASE_BITS-1:0];
    end

    // Quarter-wave polynomial sine, Q15 magnitude.
    for (genvar g = 0; g <= QSIZE; g++) begin : g_sine
        localparam logic [63:0] X      = 64'(g) << (18 - SINE_TABLE_BITS);
        localparam logic [63:0] X2     = (X * X) >> 16;
        localparam logic [63:0] INNER  = 64'd42047 - ((64'd4640 * X2) >> 16);
        localparam logic [63:0] INNER2 = 64'd102944 - ((INNER * X2) >> 16);
        localparam logic [63:0] Y      = (X * INNER2) >> 16;
        localparam logic [63:0] V      = (Y * 64'd32767 + 64'd32768) >> 16;
        localparam logic [63:0] VC     = (V > 64'd32767) ? 64'd32767 : V;
        assign sine_rom[g] = VC[SINE_MAG_W-1:0];
    end

    always_comb begin
        quad = i_phase_idx[SINE_TABLE_BITS-1 -: 2];
        if (quad[0]) begin
            rom_idx = (QBITS+1)'(QSIZE) - {1'b0, i_phase_idx[QBITS-1:0]};
        end else begin
            rom_idx = {1'b0, i_phase_idx[QBITS-1:0]};
        end
        rom_mag = sine_rom[rom_idx];
    end

    always_ff @(posedge i_clk) begin
        o_step     <= step_rom[i_note];
        o_sine_mag <= rom_mag;
        o_sine_neg <= quad[1] && (rom_mag != '0);
    end

endmodule

// ----- design/sine_voice_with_release_decay_top.sv -----
// Top level of the sine voice with release decay: sequencer, shared multiplier and state.
//
// One synthesizer voice built as a phase accumulator driving a quarter-wave sine
// table, scaled by a note level and, while releasing, by an exponential tail.
// A start item (req_type 1) resets the phase, sets the level to 0.15 times the
// velocity and loads the note's phase step from a table built at elaboration;
// it produces no result and keeps the input stalled through the level multiply
// and the step load. A stop item (req_type 2) either silences the voice at once
// or arms the tail at 1.0; it is finished in the cycle it is accepted and produces no
// result. Request type 3 is ignored. Every tick item (req_type 0) produces
// exactly one result item: the signed sample and an active flag. A tick on a
// sounding voice passes through the level multiply, the tail multiply, rounding
// with the decay multiply and the hand-off, a tick on an idle voice goes straight
// to the hand-off; all products share one 31 by 17 bit multiplier.
// A finished result sits in an output register, so the next item is taken while
// that result still waits for the downstream side; only a second result waiting
// behind a stalled one holds the sequencer. The phase and tail are advanced when
// the result is handed to the output register. Once the tail falls to 0.005 or
// less the voice goes idle.
module sine_voice_with_release_decay_top #(
    parameter int SAMPLE_RATE     = 48000,
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [svd_pkg::REQ_W-1:0]         i_req_type,
    input  logic [svd_pkg::NOTE_W-1:0]        i_note,
    input  logic [svd_pkg::VEL_W-1:0]         i_velocity,
    input  logic                              i_allow_tail,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [svd_pkg::SAMPLE_W-1:0] o_sample,
    output logic                              o_active
);
    import svd_pkg::*;

    t_state r_state, n_state;

    // Voice state.
    logic [PHASE_BITS-1:0] r_phase, n_phase;
    logic [PHASE_BITS-1:0] r_step,  n_step;
    logic [AMP_W-1:0]      r_amp,   n_amp;
    logic [TAIL_W-1:0]     r_tail,  n_tail;

    // Captured start request.
    logic [NOTE_W-1:0]     r_note,  n_note;
    logic [VEL_W-1:0]      r_vel,   n_vel;

    // Shared multiplier.
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic                  mul_en;
    logic [PROD_W-1:0]     r_prod;

    // Result waiting for the output register.
    logic [SAMPLE_W-1:0]   r_res_sample, n_res_sample;
    logic                  r_res_active, n_res_active;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0]   r_out_sample;
    logic                  r_out_active;

    // Table read data.
    logic [PHASE_BITS-1:0] tab_step;
    logic [SINE_MAG_W-1:0] tab_sine_mag;
    logic                  tab_sine_neg;

    logic                  in_acc;
    logic                  out_free;
    t_req                  req;

    // Rounding and decay arithmetic.
    logic [PROD_W:0]       sum_tail;
    logic [31:0]           sum_lvl;
    logic [16:0]           mag_raw;
    logic [SINE_MAG_W-1:0] mag_clip;
    logic [30:0]           sum_amp;
    logic [33:0]           sum_dec;
    logic [TAIL_W-1:0]     tail_dec;

    svd_tables #(
        .SAMPLE_RATE     (SAMPLE_RATE),
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_tables (
        .i_clk       (i_clk),
        .i_note      (r_note),
        .i_phase_idx (r_phase[PHASE_BITS-1 -: SINE_TABLE_BITS]),
        .o_step      (tab_step),
        .o_sine_mag  (tab_sine_mag),
        .o_sine_neg  (tab_sine_neg)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign req         = t_req'(i_req_type);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_sample    = signed'(r_out_sample);
    assign o_active    = r_out_active;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (req)
                        REQ_TICK:  n_state = (r_step == '0) ? ST_EMIT : ST_MUL_LVL;
                        REQ_START: n_state = ST_START_MUL;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_START_MUL:  n_state = ST_START_LOAD;
            ST_START_LOAD: n_state = ST_IDLE;
            ST_MUL_LVL:    n_state = ST_MUL_TAIL;
            ST_MUL_TAIL:   n_state = ST_ROUND;
            ST_ROUND:      n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    // Multiplier operand selection per state.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        unique case (r_state)
            ST_START_MUL: begin
                mul_a  = MUL_A_W'(r_vel);
                mul_b  = AMP_COEF;
                mul_en = 1'b1;
            end
            ST_MUL_LVL: begin
                mul_a  = MUL_A_W'(tab_sine_mag);
                mul_b  = MUL_B_W'(r_amp);
                mul_en = 1'b1;
            end
            ST_MUL_TAIL: begin
                mul_a  = r_prod[MUL_A_W-1:0];
                mul_b  = r_tail;
                mul_en = (r_tail != '0);
            end
            ST_ROUND: begin
                mul_a  = MUL_A_W'(r_tail);
                mul_b  = DECAY_COEF;
                mul_en = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_phase      = r_phase;
        n_step       = r_step;
        n_amp        = r_amp;
        n_tail       = r_tail;
        n_note       = r_note;
        n_vel        = r_vel;
        n_res_sample = r_res_sample;
        n_res_active = r_res_active;

        // Rounding of the level product, with or without the tail factor.
        sum_tail = {1'b0, r_prod} + (PROD_W+1)'(64'h8000_0000);
        sum_lvl  = {1'b0, r_prod[MUL_A_W-1:0]} + 32'd32768;
        if (r_tail != '0) begin
            mag_raw = sum_tail[PROD_W -: 17];
        end else begin
            mag_raw = {1'b0, sum_lvl[31:16]};
        end
        mag_clip = (mag_raw > 17'd32767) ? SINE_MAG_W'(15'h7FFF) : mag_raw[SINE_MAG_W-1:0];

        sum_amp  = r_prod[30:0] + 31'd32768;
        sum_dec  = r_prod[33:0] + 34'd32768;
        tail_dec = sum_dec[32:16];

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (req)
                        REQ_TICK: begin
                            n_res_sample = '0;
                            n_res_active = 1'b0;
                        end
                        REQ_START: begin
                            n_phase = '0;
                            n_tail  = '0;
                            n_note  = i_note;
                            n_vel   = i_velocity;
                        end
                        REQ_STOP: begin
                            if (i_allow_tail) begin
                                if (r_tail == '0) begin
                                    n_tail = TAIL_ONE;
                                end
                            end else begin
                                n_step = '0;
                            end
                        end
                        default: begin
                            n_step = r_step;
                        end
                    endcase
                end
            end
            ST_START_LOAD: begin
                n_amp  = AMP_W'(sum_amp[30:16]);
                n_step = tab_step;
            end
            ST_ROUND: begin
                n_res_active = 1'b1;
                if (tab_sine_neg) begin
                    n_res_sample = SAMPLE_W'(0) - {1'b0, mag_clip};
                end else begin
                    n_res_sample = {1'b0, mag_clip};
                end
            end
            ST_EMIT: begin
                // The voice advances when its sample is handed over.
                if (out_free && r_res_active) begin
                    n_phase = r_phase + r_step;
                    if (r_tail != '0) begin
                        n_tail = tail_dec;
                        if (tail_dec <= TAIL_END) begin
                            n_step = '0;
                        end
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Output register handshake.
    always_comb begin
        if (r_state == ST_EMIT && out_free) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_step      <= '0;
            r_amp       <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_amp       <= n_amp;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_note       <= n_note;
        r_vel        <= n_vel;
        r_res_sample <= n_res_sample;
        r_res_active <= n_res_active;
        if (mul_en) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (r_state == ST_EMIT && out_free) begin
            r_out_sample <= r_res_sample;
            r_out_active <= r_res_active;
        end
    end

endmodule

// ----- tb/tb_sine_voice_with_release_decay_top.sv -----
// Self-checking testbench of the sine voice with release decay.
module tb_sine_voice_with_release_decay_top;
    import svd_pkg::*;

    localparam int SAMPLE_RATE     = 48000;
    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam logic [63:0] PHASE_MASK = (64'd1 << PHASE_BITS) - 64'd1;
    // Request code that the block must ignore.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 950;
    localparam int CALM_ITEMS     = 100;
    localparam int HOLD_AT_ITEM   = 300;
    localparam int HOLD_CYCLES    = 200;
    localparam int IDLE_LEVELS [4] = '{0, 15, 40, 70};

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        logic              tail_ok;
    } voice_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       active;
    } voice_out_t;

    logic                i_clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type = '0;
    logic [NOTE_W-1:0]   note = '0;
    logic [VEL_W-1:0]    velocity = '0;
    logic                allow_tail = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample;
    logic                active;

    voice_req_t req_backlog [$];
    voice_out_t expected_samples [$];

    // Voice state as the predictor sees it.
    logic [31:0]       osc_phase = '0;
    logic [31:0]       osc_step = '0;
    logic [AMP_W-1:0]  note_level = '0;
    logic [TAIL_W-1:0] release_tail = '0;

    int sent_count = 0;
    int taken_count = 0;
    int planned = 0;
    int err_count = 0;
    int idle_pct = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    sine_voice_with_release_decay_top #(
        .SAMPLE_RATE    (SAMPLE_RATE),
        .PHASE_BITS     (PHASE_BITS),
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_req_type  (req_type),
        .i_note      (note),
        .i_velocity  (velocity),
        .i_allow_tail(allow_tail),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_sample    (sample),
        .o_active    (active)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one accepted request to the voice state and queues the sample a tick yields.
    function automatic void predict_voice(input voice_req_t it);
        logic [63:0] num, den, wide, x, x2, inner, inner2, y, v, mag;
        int unsigned oct, idx, quad, qidx;
        logic neg;
        voice_out_t res;
        case (it.req)
            REQ_START: begin
                osc_phase = '0;
                wide = 64'(it.vel) * 64'(AMP_COEF) + 64'd32768;
                note_level = wide[31:16];
                release_tail = '0;
                // Top octave frequency shifted down by the octave, folded into one division.
                oct = it.note / 12;
                num = 64'(TOP_OCTAVE_Q16[it.note % 12]) << PHASE_BITS;
                den = (64'(SAMPLE_RATE) << 16) << (10 - oct);
                wide = ((num + den / 2) / den) & PHASE_MASK;
                if (wide == 0)
                    wide = 64'd1;
                osc_step = wide[31:0];
            end
            REQ_STOP: begin
                if (it.tail_ok) begin
                    if (release_tail == 0)
                        release_tail = TAIL_ONE;
                end else begin
                    osc_step = '0;
                end
            end
            REQ_TICK: begin
                if (osc_step == 0) begin
                    res = '{sample: '0, active: 1'b0};
                end else begin
                    // Quarter-wave polynomial table entry for the top phase bits.
                    idx = osc_phase >> (PHASE_BITS - SINE_TABLE_BITS);
                    quad = (idx >> (SINE_TABLE_BITS - 2)) & 3;
                    qidx = idx & ((1 << (SINE_TABLE_BITS - 2)) - 1);
                    if (quad & 1)
                        qidx = (1 << (SINE_TABLE_BITS - 2)) - qidx;
                    x = 64'(qidx) << (18 - SINE_TABLE_BITS);
                    x2 = (x * x) >> 16;
                    inner = 64'd42047 - ((64'd4640 * x2) >> 16);
                    inner2 = 64'd102944 - ((inner * x2) >> 16);
                    y = (x * inner2) >> 16;
                    v = (y * 64'd32767 + 64'd32768) >> 16;
                    if (v > 64'd32767)
                        v = 64'd32767;
                    neg = (quad >= 2) && (v != 0);
                    mag = v * 64'(note_level);
                    if (release_tail != 0)
                        mag = (mag * 64'(release_tail) + (64'd1 << 31)) >> 32;
                    else
                        mag = (mag + 64'd32768) >> 16;
                    if (mag > 64'd32767)
                        mag = 64'd32767;
                    res.sample = mag[15:0];
                    if (neg)
                        res.sample = -res.sample;
                    res.active = 1'b1;
                    wide = (64'(osc_phase) + 64'(osc_step)) & PHASE_MASK;
                    osc_phase = wide[31:0];
                    if (release_tail != 0) begin
                        wide = 64'(release_tail) * 64'(DECAY_COEF) + 64'd32768;
                        release_tail = wide[32:16];
                        if (release_tail <= TAIL_END)
                            osc_step = '0;
                    end
                end
                expected_samples.push_back(res);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    task automatic queue_item(input int unsigned rq, input int unsigned nt,
                              input int unsigned vl, input int unsigned tl);
        req_backlog.push_back('{req: REQ_W'(rq), note: NOTE_W'(nt), vel: VEL_W'(vl),
                                tail_ok: 1'(tl)});
        if (REQ_W'(rq) != REQ_UNUSED)
            planned++;
    endtask

    // Ticks carry random values in the fields they do not use.
    task automatic queue_ticks(input int count);
        repeat (count)
            queue_item(REQ_TICK, $urandom_range(127), $urandom_range(65535), $urandom_range(1));
    endtask

    // The idle level changes now and then, so that calm and busy stretches alternate.
    always @(posedge i_clk) begin
        if ($urandom_range(63) == 0)
            idle_pct <= IDLE_LEVELS[$urandom_range(3)];
    end

    // Request driver: the bus is free once the item on it was taken at the last rising edge.
    always @(negedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (taken_count == sent_count) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
                {req_type, note, velocity, allow_tail} <= req_backlog.pop_front();
                in_valid <= 1'b1;
                sent_count++;
                if (req_backlog.size() >= CALM_ITEMS && $urandom_range(99) < idle_pct)
                    send_gap = $urandom_range(1, 10);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long hold-off of the result side, counted in cycles, started once enough items went in.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
        end else if (!hold_done && taken_count >= HOLD_AT_ITEM) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
    end

    // Result receiver: random stall bursts, plus the long hold-off that lets the block
    // fill up and push back on its request side while the driver keeps offering items.
    always @(negedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (req_backlog.size() >= CALM_ITEMS && $urandom_range(99) < idle_pct) begin
            stall_left = $urandom_range(0, 9);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: checks delivered samples, then predicts from the request taken at this edge.
    always @(posedge i_clk) begin
        voice_out_t exp_out;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: sample %0d active %0b",
                                              sample, active));
                end else begin
                    exp_out = expected_samples.pop_front();
                    if (sample !== exp_out.sample)
                        report_mismatch($sformatf("sample expected %0d got %0d",
                                                  exp_out.sample, sample));
                    if (active !== exp_out.active)
                        report_mismatch($sformatf("active expected %0b got %0b",
                                                  exp_out.active, active));
                end
            end
            if (in_valid && !in_stall) begin
                predict_voice('{req: req_type, note: note, vel: velocity, tail_ok: allow_tail});
                taken_count++;
            end
        end
    end

    initial begin
        // Directed part: idle tick, ignored code, the note and velocity extremes, a stop
        // with tail while a tail already runs, a silencing stop, and a tail armed while idle.
        queue_ticks(1);
        queue_item(REQ_UNUSED, 127, 65535, 1);
        queue_item(REQ_START, 69, 65535, 0);
        queue_ticks(3);
        queue_item(REQ_STOP, 0, 0, 1);
        queue_item(REQ_STOP, 127, 65535, 1);
        queue_ticks(2);
        queue_item(REQ_STOP, 0, 0, 0);
        queue_ticks(1);
        queue_item(REQ_START, 0, 0, 0);
        queue_ticks(2);
        queue_item(REQ_STOP, 0, 0, 0);
        queue_item(REQ_STOP, 0, 0, 1);
        queue_ticks(1);
        queue_item(REQ_START, 127, 65535, 1);
        queue_ticks(3);

        // One release runs all the way down until the tail ends the voice.
        planned = 0;
        queue_item(REQ_START, $urandom_range(127), $urandom_range(65535), $urandom_range(1));
        queue_ticks(4);
        queue_item(REQ_STOP, $urandom_range(127), $urandom_range(65535), 1);
        queue_ticks(560);

        // Mostly well-formed notes with random content, the rest random noise items.
        while (planned < RANDOM_ITEMS) begin
            if ($urandom_range(9) < 7) begin
                case ($urandom_range(3))
                    0: queue_item(REQ_START, $urandom_range(127), 0, $urandom_range(1));
                    1: queue_item(REQ_START, $urandom_range(127), 65535, $urandom_range(1));
                    default: queue_item(REQ_START, $urandom_range(127), $urandom_range(65535),
                                        $urandom_range(1));
                endcase
                queue_ticks($urandom_range(1, 16));
                if ($urandom_range(1)) begin
                    queue_item(REQ_STOP, $urandom_range(127), $urandom_range(65535),
                               $urandom_range(1));
                    queue_ticks($urandom_range(0, 24));
                end
            end else begin
                queue_item($urandom_range(3), $urandom_range(127), $urandom_range(65535),
                           $urandom_range(1));
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        rst_n = 1'b1;

        wait (req_backlog.size() == 0 && taken_count == sent_count);
        wait (expected_samples.size() == 0);
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
